// ===== rtl/png_chunk_framer_top_macros.svh =====
// ----------------------------------------------------------------------------
// png chunk framer assertion macros
// concurrent assertion wrappers shared by the framer rtl
// ----------------------------------------------------------------------------
`ifndef PNG_CHUNK_FRAMER_TOP_MACROS_SVH
`define PNG_CHUNK_FRAMER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/png_cf_pkg.sv =====
// ----------------------------------------------------------------------------
// png_cf_pkg
// shared types, constants and crc-32 helpers of the png chunk framer
// ----------------------------------------------------------------------------
package png_cf_pkg;

  localparam int BURST_MAX = 12;
  localparam int BURST_CNT_W = 4;

  localparam logic ACTION_BEGIN = 1'b0;
  localparam logic ACTION_DATA = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef struct packed {
    logic [7:0] value;
    logic       chunk_end;
    logic       item_done;
    logic       misuse;
  } result_t;

  typedef struct packed {
    logic                          load;
    logic [BURST_CNT_W-1:0]        count;
    result_t [BURST_MAX-1:0]       items;
  } burst_load_t;

  typedef logic [31:0] crc_table_t [256];

  function automatic crc_table_t crc_make_table();
    crc_table_t  t;
    logic [31:0] c;
    for (int n = 0; n < 256; n++) begin
      c = 32'(n);
      for (int k = 0; k < 8; k++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      t[n[7:0]] = c;
    end
    return t;
  endfunction

  localparam crc_table_t CRC_TABLE = crc_make_table();

  // one byte folded into the running (non-inverted) crc
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    return CRC_TABLE[c[7:0] ^ b] ^ {8'h00, c[31:8]};
  endfunction

endpackage

// ===== rtl/png_cf_burst.sv =====
// ----------------------------------------------------------------------------
// png_cf_burst
// result burst buffer: loads up to twelve output bytes, shifts one out per take
// ----------------------------------------------------------------------------
module png_cf_burst (
  input  logic                    clk,
  input  logic                    rst,
  input  png_cf_pkg::burst_load_t ld,
  output logic                    can_load,
  output logic                    out_valid,
  input  logic                    out_ready,
  output png_cf_pkg::result_t     out_item
);

  logic [png_cf_pkg::BURST_CNT_W-1:0] count;
  png_cf_pkg::result_t                items [png_cf_pkg::BURST_MAX];
  logic                               take;

  assign out_valid = (count != '0);
  assign take      = out_valid && out_ready;
  // empty, or the last byte leaves this cycle
  assign can_load  = (count == '0) ||
                     ((count == png_cf_pkg::BURST_CNT_W'(1)) && out_ready);
  assign out_item  = items[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ld.load) begin
      count <= ld.count;
    end else if (take) begin
      count <= count - png_cf_pkg::BURST_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      for (int i = 0; i < png_cf_pkg::BURST_MAX; i++) begin
        items[i] <= ld.items[i];
      end
    end else if (take) begin
      for (int i = 0; i < png_cf_pkg::BURST_MAX - 1; i++) begin
        items[i] <= items[i+1];
      end
    end
  end

endmodule

// ===== rtl/png_chunk_framer_top.sv =====
// ----------------------------------------------------------------------------
// png_chunk_framer_top
// png chunk framer: length, tag, payload and crc-32 as one byte stream
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): action 0 begins a chunk with chunk_tag
//   and chunk_length, action 1 carries one payload byte in data_byte
//   output channel (out_valid/out_ready): one framed byte per handshake, with
//   chunk_end on the final crc byte, item_done on the last byte caused by an
//   input request and misuse on a rejected request (data with no open chunk,
//   or begin inside one)
//   path: a request is registered, then built into the burst buffer once
//   the buffer can load; its first byte then shows on the output
//   throughput: one output byte per cycle while out_ready is high, set by the
//   single output port of the burst buffer; a payload byte makes one result,
//   so payload streams at one request per cycle while out_ready holds; a begin
//   makes 8 bytes (12 with zero length), the data byte that closes a chunk 5
//   one request waits in the input register while a burst drains, so input
//   is taken even when the receiver stalls on a pending result
//   reset: crc back to all ones, no open chunk, both buffers empty
//   receiver stall: bytes hold on the output, the input register fills and
//   then in_ready drops
// ----------------------------------------------------------------------------
`include "png_chunk_framer_top_macros.svh"

module png_chunk_framer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] chunk_tag,
  input  logic [30:0] chunk_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        chunk_end,
  output logic        item_done,
  output logic        misuse
);

  // chunk state
  logic [31:0] crc_acc;
  logic [31:0] crc_acc_next;
  logic [30:0] bytes_left;
  logic [30:0] bytes_left_next;
  logic        chunk_open;
  logic        chunk_open_next;

  // input register
  logic        inq_valid;
  logic        inq_action;
  logic [31:0] inq_tag;
  logic [30:0] inq_length;
  logic [7:0]  inq_data;
  logic [31:0] inq_crc_part;   // crc over the first two tag bytes

  logic                    in_fire;
  logic                    consume;
  logic                    can_load;
  png_cf_pkg::burst_load_t ld;
  png_cf_pkg::result_t     out_item;

  // combinational build values
  logic [31:0] tag_crc;
  logic [31:0] tag_crc_out;
  logic [31:0] data_crc;
  logic [31:0] data_crc_out;
  logic [30:0] bytes_dec;
  logic [31:0] len_word;

  assign in_fire = in_valid && in_ready;
  assign consume = inq_valid && can_load;
  assign in_ready = !inq_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else begin
      inq_valid <= in_fire || (inq_valid && !consume);
    end
  end

  // payload fields, plus a head start on the tag crc
  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_action   <= action;
      inq_tag      <= chunk_tag;
      inq_length   <= chunk_length;
      inq_data     <= data_byte;
      inq_crc_part <= png_cf_pkg::crc_step(
                        png_cf_pkg::crc_step(png_cf_pkg::CRC_INIT, chunk_tag[31:24]),
                        chunk_tag[23:16]);
    end
  end

  assign tag_crc      = png_cf_pkg::crc_step(png_cf_pkg::crc_step(inq_crc_part,
                                                                  inq_tag[15:8]),
                                             inq_tag[7:0]);
  assign tag_crc_out  = tag_crc ^ png_cf_pkg::CRC_INIT;
  assign data_crc     = png_cf_pkg::crc_step(crc_acc, inq_data);
  assign data_crc_out = data_crc ^ png_cf_pkg::CRC_INIT;
  assign bytes_dec    = bytes_left - 31'd1;
  assign len_word     = {1'b0, inq_length};

  // build the burst for the registered request and the next chunk state
  always_comb begin
    ld              = '0;
    ld.load         = consume;
    crc_acc_next    = crc_acc;
    bytes_left_next = bytes_left;
    chunk_open_next = chunk_open;

    case (inq_action)
      png_cf_pkg::ACTION_BEGIN: begin
        if (chunk_open) begin
          // begin inside an open chunk: flagged and dropped
          ld.count             = png_cf_pkg::BURST_CNT_W'(1);
          ld.items[0].item_done = 1'b1;
          ld.items[0].misuse    = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            ld.items[i].value   = len_word[31-8*i -: 8];
            ld.items[4+i].value = inq_tag[31-8*i -: 8];
          end
          if (inq_length == '0) begin
            // empty chunk: crc follows the tag at once
            for (int i = 0; i < 4; i++) begin
              ld.items[8+i].value = tag_crc_out[31-8*i -: 8];
            end
            ld.items[11].chunk_end = 1'b1;
            ld.items[11].item_done = 1'b1;
            ld.count               = png_cf_pkg::BURST_CNT_W'(12);
            crc_acc_next           = png_cf_pkg::CRC_INIT;
            bytes_left_next        = '0;
            chunk_open_next        = 1'b0;
          end else begin
            ld.items[7].item_done = 1'b1;
            ld.count              = png_cf_pkg::BURST_CNT_W'(8);
            crc_acc_next          = tag_crc;
            bytes_left_next       = inq_length;
            chunk_open_next       = 1'b1;
          end
        end
      end
      png_cf_pkg::ACTION_DATA: begin
        if (!chunk_open) begin
          // payload byte with no chunk: flagged and dropped
          ld.count              = png_cf_pkg::BURST_CNT_W'(1);
          ld.items[0].item_done = 1'b1;
          ld.items[0].misuse    = 1'b1;
        end else if (bytes_dec != '0) begin
          ld.count              = png_cf_pkg::BURST_CNT_W'(1);
          ld.items[0].value     = inq_data;
          ld.items[0].item_done = 1'b1;
          crc_acc_next          = data_crc;
          bytes_left_next       = bytes_dec;
        end else begin
          // last payload byte closes the chunk with its crc
          ld.items[0].value = inq_data;
          for (int i = 0; i < 4; i++) begin
            ld.items[1+i].value = data_crc_out[31-8*i -: 8];
          end
          ld.items[4].chunk_end = 1'b1;
          ld.items[4].item_done = 1'b1;
          ld.count              = png_cf_pkg::BURST_CNT_W'(5);
          crc_acc_next          = png_cf_pkg::CRC_INIT;
          bytes_left_next       = '0;
          chunk_open_next       = 1'b0;
        end
      end
      default: begin
        ld.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc    <= png_cf_pkg::CRC_INIT;
      bytes_left <= '0;
      chunk_open <= 1'b0;
    end else if (consume) begin
      crc_acc    <= crc_acc_next;
      bytes_left <= bytes_left_next;
      chunk_open <= chunk_open_next;
    end
  end

  png_cf_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign out_byte  = out_item.value;
  assign chunk_end = out_item.chunk_end;
  assign item_done = out_item.item_done;
  assign misuse    = out_item.misuse;

  // an open chunk always expects more payload, a closed one none
  `PCF_ASSERT_NOW(a_open_matches_count, 1'b1, chunk_open == (bytes_left != '0),
                  "chunk_open disagrees with bytes_left")
  // crc register is back at its seed whenever no chunk is open
  `PCF_ASSERT_NOW(a_crc_idle_seed, !chunk_open, crc_acc == png_cf_pkg::CRC_INIT,
                  "crc not reseeded outside a chunk")
  // the closing crc byte ends its request and is never a rejection
  `PCF_ASSERT_NOW(a_end_is_done, out_valid && chunk_end, item_done && !misuse,
                  "chunk_end without item_done or with misuse")
  // a loaded burst is never empty, so the result shows next cycle
  `PCF_ASSERT_NEXT(a_load_shows, ld.load, out_valid,
                   "burst loaded but no output valid")

endmodule
